### sv/wildcard_byte_pattern_scanner_top_defines.svh
// Assertion macros for the scanner RTL.
`ifndef WILDCARD_BYTE_PATTERN_SCANNER_TOP_DEFINES_SVH
`define WILDCARD_BYTE_PATTERN_SCANNER_TOP_DEFINES_SVH

`ifndef SYNTHESIS
`define WBPS_ASSERT_SAME(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);
`define WBPS_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);
`else
`define WBPS_ASSERT_SAME(label, clk, rstn, ante, cons, msg)
`define WBPS_ASSERT_NEXT(label, clk, rstn, ante, cons, msg)
`endif

`endif

### sv/wbps_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package wbps_pkg;

    localparam int ADDR_W     = 48;
    localparam int CNT_W      = 16;
    localparam int CFG_DATA_W = 64;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_LEN_W  = 5;
    localparam int PAT_BYTES  = 16;
    localparam int PAT_IDX_W  = 4;

    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LOW    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_HIGH   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CARE_MASK      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTH = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_MATCHES    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_BASE_ADDRESS   = 3'd5;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } wbps_in_t;

    typedef struct packed {
        logic [ADDR_W-1:0] match_address;
        logic [CNT_W-1:0]  match_number;
    } wbps_out_t;

    typedef struct packed {
        logic       care;
        logic [7:0] want;
    } wbps_cmp_t;

endpackage

`default_nettype wire

### sv/wildcard_byte_pattern_scanner_top.sv
`timescale 1ns / 1ps
`default_nettype none
// Throughput: 1 byte per cycle while s_ready is high; each window cell compares its byte
// in the cycle it shifts; a match is registered once more before it goes out on m_.
// Reset (aresetn low at a clock edge) restores the registers to their reset values and
// clears the offset, the match counter and all valid flags; window bytes need no reset.
// A byte with last_byte set clears the offset and the match counter after its compare.

`include "wildcard_byte_pattern_scanner_top_defines.svh"

module wildcard_byte_pattern_scanner_top #(
    parameter int PATTERN_MAX = 16
) (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire logic                                 s_valid,
    output logic                                      s_ready,
    input  wire wbps_pkg::wbps_in_t                   s_data,
    output logic                                      m_valid,
    input  wire logic                                 m_ready,
    output wbps_pkg::wbps_out_t                       m_data,
    input  wire logic                                 cfg_we,
    input  wire logic [wbps_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [wbps_pkg::CFG_DATA_W-1:0]      cfg_data
);

    localparam int LEN_W = ($clog2(PATTERN_MAX + 1) > wbps_pkg::CFG_LEN_W) ?
                           $clog2(PATTERN_MAX + 1) : wbps_pkg::CFG_LEN_W;
    localparam int ADDR_W = wbps_pkg::ADDR_W;
    localparam int CNT_W  = wbps_pkg::CNT_W;

    logic [63:0]                     pattern_low_reg;
    logic [63:0]                     pattern_high_reg;
    logic [wbps_pkg::PAT_BYTES-1:0]  care_mask_reg;
    logic [wbps_pkg::CFG_LEN_W-1:0]  pattern_length_reg;
    logic [CNT_W-1:0]                max_matches_reg;
    logic [ADDR_W-1:0]               base_address_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pattern_low_reg    <= '0;
            pattern_high_reg   <= '0;
            care_mask_reg      <= '0;
            pattern_length_reg <= wbps_pkg::CFG_LEN_W'(1);
            max_matches_reg    <= '0;
            base_address_reg   <= '0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                wbps_pkg::REG_PATTERN_LOW: begin
                    pattern_low_reg <= cfg_data;
                end
                wbps_pkg::REG_PATTERN_HIGH: begin
                    pattern_high_reg <= cfg_data;
                end
                wbps_pkg::REG_CARE_MASK: begin
                    care_mask_reg <= cfg_data[wbps_pkg::PAT_BYTES-1:0];
                end
                wbps_pkg::REG_PATTERN_LENGTH: begin
                    pattern_length_reg <= cfg_data[wbps_pkg::CFG_LEN_W-1:0];
                end
                wbps_pkg::REG_MAX_MATCHES: begin
                    max_matches_reg <= cfg_data[CNT_W-1:0];
                end
                wbps_pkg::REG_BASE_ADDRESS: begin
                    base_address_reg <= cfg_data[ADDR_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    logic [LEN_W-1:0] len_ext;
    logic [LEN_W-1:0] len_eff;
    logic [LEN_W-1:0] len_m1;

    always_comb begin
        len_ext = LEN_W'(pattern_length_reg);
        len_eff = len_ext;
        if (len_ext == '0) begin
            len_eff = LEN_W'(1);
        end else if (len_ext > LEN_W'(PATTERN_MAX)) begin
            len_eff = LEN_W'(PATTERN_MAX);
        end
        len_m1 = len_eff - LEN_W'(1);
    end

    logic [wbps_pkg::PAT_BYTES-1:0][7:0] pat_bytes;
    assign pat_bytes = {pattern_high_reg, pattern_low_reg};

    logic                    s_xfer;
    logic                    s1_adv;
    logic                    s1_valid_reg;
    logic                    s1_valid_next;
    logic                    s1_last_reg;
    logic                    s1_elig_reg;
    logic [ADDR_W-1:0]       s1_start_reg;
    logic [ADDR_W-1:0]       offset_reg;
    logic [ADDR_W-1:0]       offset_next;
    logic [ADDR_W-1:0]       len_m1_wide;

    logic [PATTERN_MAX-1:0][7:0] win_bytes;
    logic [PATTERN_MAX-1:0]      win_hits;

    genvar k;
    generate
        for (k = 0; k < PATTERN_MAX; k++) begin : g_cell
            logic [LEN_W-1:0]     pos;
            wbps_pkg::wbps_cmp_t  cmp;
            logic [7:0]           din;

            always_comb begin
                pos      = len_m1 - LEN_W'(k);
                cmp.want = pat_bytes[pos[wbps_pkg::PAT_IDX_W-1:0]];
                cmp.care = (LEN_W'(k) <= len_m1)
                           && (pos < LEN_W'(wbps_pkg::PAT_BYTES))
                           && care_mask_reg[pos[wbps_pkg::PAT_IDX_W-1:0]];
            end

            if (k == 0) begin : g_head
                assign din = s_data.data_byte;
            end else begin : g_body
                assign din = win_bytes[k-1];
            end

            wbps_cell u_cell (
                .aclk     (aclk),
                .shift_en (s_xfer),
                .byte_in  (din),
                .cmp      (cmp),
                .byte_out (win_bytes[k]),
                .hit      (win_hits[k])
            );
        end
    endgenerate

    logic                 m_valid_reg;
    logic                 m_valid_next;
    wbps_pkg::wbps_out_t  m_data_reg;
    logic [CNT_W-1:0]     found_count_reg;
    logic [CNT_W-1:0]     found_count_next;
    logic [CNT_W-1:0]     count_inc;
    logic                 s1_fire;

    assign s1_adv  = !m_valid_reg || m_ready;
    assign s_ready = !s1_valid_reg || s1_adv;
    assign s_xfer  = s_valid && s_ready;
    assign len_m1_wide = ADDR_W'(len_m1);

    always_comb begin
        offset_next = offset_reg;
        if (s_xfer) begin
            offset_next = s_data.last_byte ? '0 : offset_reg + ADDR_W'(1);
        end
        s1_valid_next = s1_valid_reg;
        if (s_xfer) begin
            s1_valid_next = 1'b1;
        end else if (s1_adv) begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            offset_reg   <= '0;
            s1_valid_reg <= 1'b0;
        end else begin
            offset_reg   <= offset_next;
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            s1_last_reg  <= s_data.last_byte;
            s1_elig_reg  <= offset_reg >= len_m1_wide;
            s1_start_reg <= offset_reg - len_m1_wide;
        end
    end

    always_comb begin
        count_inc = (found_count_reg == {CNT_W{1'b1}}) ?
                    found_count_reg : found_count_reg + CNT_W'(1);
        s1_fire   = s1_valid_reg && s1_adv && s1_elig_reg && (&win_hits)
                    && ((max_matches_reg == '0) || (found_count_reg < max_matches_reg));
        found_count_next = found_count_reg;
        if (s1_valid_reg && s1_adv && s1_last_reg) begin
            found_count_next = '0;
        end else if (s1_fire) begin
            found_count_next = count_inc;
        end
        m_valid_next = m_valid_reg && !m_ready;
        if (s1_fire) begin
            m_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            found_count_reg <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            found_count_reg <= found_count_next;
            m_valid_reg     <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_fire) begin
            m_data_reg.match_address <= base_address_reg + s1_start_reg;
            m_data_reg.match_number  <= count_inc;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    `WBPS_ASSERT_SAME(a_number_nonzero, aclk, aresetn, m_valid_reg,
                      m_data_reg.match_number != '0, "match number is zero")
    `WBPS_ASSERT_NEXT(a_last_clears, aclk, aresetn,
                      s1_valid_reg && s1_adv && s1_last_reg, found_count_reg == '0,
                      "last byte did not clear the match counter")
    `WBPS_ASSERT_SAME(a_stall_only_full, aclk, aresetn, !s_ready,
                      s1_valid_reg && m_valid_reg && !m_ready,
                      "input stalled with room in the pipeline")

endmodule

`default_nettype wire

### sv/wbps_cell.sv
`timescale 1ns / 1ps
`default_nettype none

module wbps_cell (
    input  wire logic               aclk,
    input  wire logic               shift_en,
    input  wire logic [7:0]         byte_in,
    input  wire wbps_pkg::wbps_cmp_t cmp,
    output logic      [7:0]         byte_out,
    output logic                    hit
);

    logic [7:0] byte_reg;
    logic [7:0] byte_next;
    logic       hit_reg;
    logic       hit_next;

    always_comb begin
        byte_next = byte_reg;
        hit_next  = hit_reg;
        if (shift_en) begin
            byte_next = byte_in;
            hit_next  = !cmp.care || (byte_in == cmp.want);
        end
    end

    always_ff @(posedge aclk) begin
        byte_reg <= byte_next;
        hit_reg  <= hit_next;
    end

    assign byte_out = byte_reg;
    assign hit      = hit_reg;

endmodule

`default_nettype wire

### bench/wildcard_byte_pattern_scanner_top_tb.sv
`timescale 1ns / 1ps

module wildcard_byte_pattern_scanner_top_tb;
    import wbps_pkg::*;

    localparam int WATCHDOG_LIMIT   = 4000;
    localparam int LONG_HOLD_CYCLES = 400;
    localparam int LONG_HOLD_ITEMS  = 120;
    localparam int SETTLE_CYCLES    = 6;
    localparam int PHASE_ITEMS      = 75;
    localparam int RANDOM_PHASES    = 12;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_valid   = 1'b0;
    logic                  s_ready;
    wbps_in_t              s_data    = '0;
    logic                  m_valid;
    logic                  m_ready   = 1'b0;
    wbps_out_t             m_data;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    logic [63:0]        cfg_pat_lo = '0;
    logic [63:0]        cfg_pat_hi = '0;
    logic [15:0]        cfg_care   = '0;
    logic [4:0]         cfg_len    = 5'd1;
    logic [15:0]        cfg_max    = '0;
    logic [ADDR_W-1:0]  cfg_base   = '0;

    logic [7:0]         scan_window [PAT_BYTES];
    logic [ADDR_W-1:0]  scan_offset;
    logic [CNT_W-1:0]   found_count;

    wbps_in_t  pending_bytes [$];
    wbps_out_t expected_matches [$];
    int        queued_items   = 0;
    int        mismatches     = 0;
    int        send_idle_pct  = 0;
    int        recv_stall_pct = 0;
    bit        long_hold_req  = 1'b0;
    bit        hold_taken     = 1'b0;
    int        hold_left      = 0;

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    wildcard_byte_pattern_scanner_top u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    function automatic int active_length();
        int l;
        l = cfg_len;
        if (l == 0) l = 1;
        if (l > PAT_BYTES) l = PAT_BYTES;
        return l;
    endfunction

    function automatic logic [7:0] pattern_byte(input int i);
        return (i < 8) ? cfg_pat_lo[8*i +: 8] : cfg_pat_hi[8*(i-8) +: 8];
    endfunction

    task automatic clear_scan();
        foreach (scan_window[i]) scan_window[i] = 8'h00;
        scan_offset = '0;
        found_count = '0;
    endtask

    task automatic scan_byte(input wbps_in_t item);
        int                l;
        bit                hit;
        logic [ADDR_W-1:0] start;
        wbps_out_t         res;
        l = active_length();
        for (int i = PAT_BYTES - 1; i > 0; i--) scan_window[i] = scan_window[i-1];
        scan_window[0] = item.data_byte;
        hit = ({1'b0, scan_offset} + 49'd1) >= 49'(l);
        for (int i = 0; i < l; i++) begin
            if (cfg_care[i] && pattern_byte(i) != scan_window[l-1-i]) hit = 1'b0;
        end
        if (hit && (cfg_max == 0 || found_count < cfg_max)) begin
            if (found_count != 16'hFFFF) found_count++;
            start = scan_offset + 48'd1 - 48'(l);
            res.match_address = cfg_base + start;
            res.match_number  = found_count;
            expected_matches.push_back(res);
        end
        scan_offset = scan_offset + 48'd1;
        if (item.last_byte) clear_scan();
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            clear_scan();
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) scan_byte(s_data);
            if (!s_valid || s_ready) begin
                if (pending_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    s_valid <= 1'b1;
                    s_data  <= pending_bytes.pop_front();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    task automatic flag_error(input string what, input logic [63:0] exp, input logic [63:0] act);
        mismatches++;
        if (mismatches <= 10)
            $display("Mismatch in %s: expected %h, got %h", what, exp, act);
    endtask

    always @(posedge aclk) begin
        wbps_out_t exp;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_matches.size() == 0) begin
                    flag_error("unexpected transfer", '0, 64'(m_data));
                end else begin
                    exp = expected_matches.pop_front();
                    if (m_data.match_address !== exp.match_address)
                        flag_error("match_address", 64'(exp.match_address),
                                   64'(m_data.match_address));
                    if (m_data.match_number !== exp.match_number)
                        flag_error("match_number", 64'(exp.match_number),
                                   64'(m_data.match_number));
                end
            end
            if (long_hold_req && !hold_taken) begin
                hold_left  = LONG_HOLD_CYCLES;
                hold_taken = 1'b1;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] val);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        case (idx)
            REG_PATTERN_LOW:    cfg_pat_lo = val;
            REG_PATTERN_HIGH:   cfg_pat_hi = val;
            REG_CARE_MASK:      cfg_care   = val[15:0];
            REG_PATTERN_LENGTH: cfg_len    = val[4:0];
            REG_MAX_MATCHES:    cfg_max    = val[15:0];
            REG_BASE_ADDRESS:   cfg_base   = val[ADDR_W-1:0];
            default: ;
        endcase
    endtask

    task automatic end_writes();
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    task automatic drain();
        @(negedge aclk);
        while (pending_bytes.size() != 0 || s_valid || expected_matches.size() != 0)
            @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic set_idle(input int send_pct, input int recv_pct);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
    endtask

    task automatic push_byte(input logic [7:0] d, input bit last);
        wbps_in_t it;
        it.data_byte = d;
        it.last_byte = last;
        pending_bytes.push_back(it);
        queued_items++;
    endtask

    // Mostly planted pattern occurrences with random wildcard bytes, some of
    // them corrupted, separated by noise that often repeats pattern bytes.
    task automatic push_region(input bit with_last);
        logic [7:0] bytes [$];
        int         l;
        int         units;
        int         broken;
        logic [7:0] b;
        l = active_length();
        units = $urandom_range(1, 6);
        for (int u = 0; u < units; u++) begin
            if ($urandom_range(99) < 70) begin
                broken = ($urandom_range(99) < 15) ? $urandom_range(l - 1) : -1;
                for (int j = 0; j < l; j++) begin
                    b = cfg_care[j] ? pattern_byte(j) : 8'($urandom);
                    if (j == broken) b = ~b;
                    bytes.push_back(b);
                end
            end else begin
                repeat ($urandom_range(1, 4))
                    bytes.push_back($urandom_range(1) ? pattern_byte($urandom_range(l - 1))
                                                      : 8'($urandom));
            end
        end
        foreach (bytes[k]) push_byte(bytes[k], with_last && k == bytes.size() - 1);
    endtask

    task automatic random_config(input int ph);
        int          len_pick [5] = '{0, 16, 31, 1, 17};
        logic [63:0] val;
        write_reg(REG_PATTERN_LOW, {$urandom, $urandom});
        write_reg(REG_PATTERN_HIGH, {$urandom, $urandom});
        case ($urandom_range(3))
            0: val = 64'h0000;
            1: val = 64'hFFFF;
            default: val = 64'($urandom_range(16'hFFFF));
        endcase
        write_reg(REG_CARE_MASK, val);
        val = (ph < 5) ? 64'(len_pick[ph]) : 64'($urandom_range(31));
        write_reg(REG_PATTERN_LENGTH, val);
        case ($urandom_range(5))
            0: val = 64'($urandom_range(1, 4));
            1: val = 64'hFFFF;
            default: val = 64'h0;
        endcase
        write_reg(REG_MAX_MATCHES, val);
        case ($urandom_range(3))
            0: val = 64'(48'hFFFF_FFFF_FFFF - 48'($urandom_range(40)));
            1: val = 64'h0;
            default: val = 64'({$urandom, $urandom} & 64'hFFFF_FFFF_FFFF);
        endcase
        write_reg(REG_BASE_ADDRESS, val);
        if (ph == 0) write_reg(REG_UNUSED, {$urandom, $urandom});
        end_writes();
    endtask

    initial begin
        int stalled;
        stalled = 0;
        while (stalled < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready))
                stalled = 0;
            else
                stalled++;
        end
        $display("Test completed with failures");
        $finish;
    end

    initial begin
        int start;
        bit paused;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        set_idle(0, 0);
        push_byte(8'h00, 1'b0);
        push_byte(8'hFF, 1'b0);
        push_byte(8'hA5, 1'b1);
        drain();

        // A length of zero acts as one; the address wraps past the top.
        write_reg(REG_PATTERN_LENGTH, 64'd0);
        write_reg(REG_CARE_MASK, 64'hFFFF);
        write_reg(REG_PATTERN_LOW, 64'h0123_4567_89AB_CD5A);
        write_reg(REG_BASE_ADDRESS, 64'hFFFF_FFFF_FFFE);
        end_writes();
        push_byte(8'h5A, 1'b0);
        push_byte(8'h00, 1'b0);
        push_byte(8'h5A, 1'b0);
        push_byte(8'h5A, 1'b1);
        drain();

        // A region shorter than the pattern, then one that just holds it.
        write_reg(REG_PATTERN_LENGTH, 64'd4);
        write_reg(REG_CARE_MASK, 64'h000F);
        end_writes();
        push_byte(8'h5A, 1'b0);
        push_byte(8'hCD, 1'b0);
        push_byte(8'hAB, 1'b1);
        push_byte(8'h5A, 1'b0);
        push_byte(8'hCD, 1'b0);
        push_byte(8'hAB, 1'b0);
        push_byte(8'h89, 1'b1);
        drain();

        // The report limit stops further matches within the region.
        write_reg(REG_PATTERN_LENGTH, 64'd1);
        write_reg(REG_CARE_MASK, 64'h0);
        write_reg(REG_MAX_MATCHES, 64'd2);
        write_reg(REG_BASE_ADDRESS, 64'h0);
        end_writes();
        push_byte(8'h00, 1'b0);
        push_byte(8'hFF, 1'b0);
        push_byte(8'h00, 1'b0);
        push_byte(8'hFF, 1'b1);
        drain();

        // Registers changed in the middle of a region apply to the next byte.
        write_reg(REG_MAX_MATCHES, 64'd0);
        end_writes();
        push_byte(8'h11, 1'b0);
        push_byte(8'h22, 1'b0);
        drain();
        write_reg(REG_BASE_ADDRESS, 64'h1000);
        write_reg(REG_PATTERN_LENGTH, 64'd2);
        end_writes();
        push_byte(8'h33, 1'b0);
        push_byte(8'h44, 1'b1);
        drain();

        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            case (ph % 4)
                0: set_idle(0, 0);
                1: set_idle(67, 0);
                2: set_idle(0, 67);
                default: set_idle(29, 29);
            endcase
            random_config(ph);
            start = queued_items;
            paused = 1'b0;
            while (queued_items - start < PHASE_ITEMS) begin
                push_region($urandom_range(99) < 80);
                if (ph == 1 && !paused && queued_items - start >= PHASE_ITEMS / 2) begin
                    drain();
                    paused = 1'b1;
                end
            end
            drain();

            if (ph == 2) begin
                // Every byte matches while the receiver holds off for a long stretch.
                set_idle(0, 0);
                write_reg(REG_PATTERN_LENGTH, 64'd1);
                write_reg(REG_CARE_MASK, 64'h0);
                write_reg(REG_MAX_MATCHES, 64'd0);
                end_writes();
                long_hold_req = 1'b1;
                for (int k = 0; k < LONG_HOLD_ITEMS; k++)
                    push_byte(8'($urandom), k == LONG_HOLD_ITEMS - 1);
                drain();
            end
        end

        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (mismatches == 0 && expected_matches.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

### files.f
+incdir+sv
sv/wbps_pkg.sv
sv/wbps_cell.sv
sv/wildcard_byte_pattern_scanner_top.sv
bench/wildcard_byte_pattern_scanner_top_tb.sv
